>>> design/sliding_window_sender_assert.svh
// Assertion macros used by the sliding window sender RTL.
`ifndef SLIDING_WINDOW_SENDER_ASSERT_SVH
`define SLIDING_WINDOW_SENDER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sws_pkg.sv
`timescale 1ns / 1ps
package sws_pkg;

  // Event codes carried by an input transfer.
  typedef enum logic [1:0] {
    ACT_SEND = 2'd0,
    ACT_ACK  = 2'd1,
    ACT_TICK = 2'd2,
    ACT_OPEN = 2'd3
  } action_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [5:0]  WINDOW_LIMIT_RST  = 6'd30;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

  typedef struct packed {
    action_t     action;
    logic [31:0] ack_number;
    logic        checksum_ok;
    logic [15:0] credit_grant;
  } sws_in_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] seq_number;
    logic        resend;
    logic [5:0]  released;
    logic [5:0]  occupancy;
    logic [15:0] credit_left;
  } sws_out_t;

endpackage

>>> design/sliding_window_sender.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | sws_pkg::sws_in_t
// out_    | output    | out_valid/out_stall| sws_pkg::sws_out_t
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle while in_stall is low: each event updates the window
// pointers, credit and clock, and its result is registered for one transfer.
// The head stamp is read from the stamp RAM in the cycle before, at the next
// head slot, with a bypass for a write to that same slot.
// Reset is synchronous; the stamp RAM needs no clearing pass.
// in_stall is raised only while a held result is stalled at the output.
module sliding_window_sender #(
  parameter int unsigned WINDOW_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sws_pkg::sws_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sws_pkg::sws_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sws_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sws_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import sws_pkg::*;

  `include "sliding_window_sender_assert.svh"

  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W  = CNT_W + 1;
  localparam int unsigned CMP_W  = (CNT_W > 6) ? CNT_W : 6;

  // Configuration registers
  logic [5:0]  window_limit_r;
  logic [15:0] timeout_ticks_r;

  // Window state
  logic [SLOT_W-1:0] head_slot_r,   head_slot_nxt;
  logic [CNT_W-1:0]  entry_count_r, entry_count_nxt;
  logic [31:0]       head_seq_r,    head_seq_nxt;
  logic [31:0]       next_seq_r,    next_seq_nxt;
  logic [15:0]       credit_r,      credit_nxt;
  logic [31:0]       now_r,         now_nxt;

  // Result register
  logic     out_valid_r;
  sws_out_t out_data_r, out_data_nxt;

  // Stamp RAM and head bypass
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic [31:0]       ram_rdata;
  logic              byp_hit_r, byp_hit_nxt;
  logic [31:0]       byp_data_r;
  logic [31:0]       head_stamp;

  // Datapath intermediates
  logic              in_fire;
  logic [CMP_W-1:0]  limit_eff;
  logic              can_send;
  logic [SUM_W-1:0]  tail_sum;
  logic [SLOT_W-1:0] tail_slot;
  logic [31:0]       ack_dist;
  logic              ack_ok;
  logic [CNT_W-1:0]  rel_cnt;
  logic [SUM_W-1:0]  head_sum;
  logic [16:0]       credit_sum;
  logic [31:0]       tick_now;
  logic [31:0]       head_age;
  logic              time_out;

  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_limit_r  <= WINDOW_LIMIT_RST;
      timeout_ticks_r <= TIMEOUT_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WINDOW_LIMIT) begin
        window_limit_r <= cfg_data[5:0];
      end
      if (cfg_index == CFG_TIMEOUT_TICKS) begin
        timeout_ticks_r <= cfg_data[15:0];
      end
    end
  end

  // The head stamp is the registered RAM read unless the head slot was
  // written in the same cycle as the read was issued.
  assign head_stamp = byp_hit_r ? byp_data_r : ram_rdata;

  // Admission check against the limit clipped to the window depth and nonzero credit.
  always_comb begin
    limit_eff = (CMP_W'(window_limit_r) > CMP_W'(WINDOW_DEPTH)) ?
                CMP_W'(WINDOW_DEPTH) : CMP_W'(window_limit_r);
    can_send  = (CMP_W'(entry_count_r) < limit_eff) && (credit_r != 16'd0);
  end

  // Slot after the last entry, wrapped once.
  always_comb begin
    tail_sum  = SUM_W'(head_slot_r) + SUM_W'(entry_count_r);
    if (tail_sum >= SUM_W'(WINDOW_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(WINDOW_DEPTH);
    end
    tail_slot = tail_sum[SLOT_W-1:0];
  end

  // Cumulative ack: number of entries freed and the new head slot.
  always_comb begin
    ack_dist = in_data.ack_number - head_seq_r;
    ack_ok   = in_data.checksum_ok && (entry_count_r != '0) && !ack_dist[31];
    rel_cnt  = (ack_dist >= 32'(entry_count_r)) ? entry_count_r :
               CNT_W'(ack_dist + 32'd1);
    head_sum = SUM_W'(head_slot_r) + SUM_W'(rel_cnt);
    if (head_sum >= SUM_W'(WINDOW_DEPTH)) begin
      head_sum = head_sum - SUM_W'(WINDOW_DEPTH);
    end
    credit_sum = {1'b0, credit_r} + 17'(rel_cnt);
  end

  // Tick: age of the head entry against the timeout.
  always_comb begin
    tick_now = now_r + 32'd1;
    head_age = tick_now - head_stamp;
    time_out = (entry_count_r != '0) && (head_age > 32'(timeout_ticks_r));
  end

  // Next state, stamp write and result for the accepted event.
  always_comb begin
    head_slot_nxt   = head_slot_r;
    entry_count_nxt = entry_count_r;
    head_seq_nxt    = head_seq_r;
    next_seq_nxt    = next_seq_r;
    credit_nxt      = credit_r;
    now_nxt         = now_r;
    ram_we          = 1'b0;
    ram_waddr       = tail_slot;
    ram_wdata       = now_r;
    out_data_nxt    = '0;
    if (in_fire) begin
      unique case (in_data.action)
        ACT_SEND: begin
          if (can_send) begin
            credit_nxt              = credit_r - 16'd1;
            ram_we                  = 1'b1;
            entry_count_nxt         = entry_count_r + CNT_W'(1);
            next_seq_nxt            = next_seq_r + 32'd1;
            out_data_nxt.accepted   = 1'b1;
            out_data_nxt.seq_number = next_seq_r;
          end
        end
        ACT_ACK: begin
          if (ack_ok) begin
            entry_count_nxt       = entry_count_r - rel_cnt;
            head_slot_nxt         = head_sum[SLOT_W-1:0];
            head_seq_nxt          = head_seq_r + 32'(rel_cnt);
            credit_nxt            = credit_sum[16] ? 16'hFFFF : credit_sum[15:0];
            out_data_nxt.released = 6'(rel_cnt);
          end
        end
        ACT_TICK: begin
          now_nxt = tick_now;
          if (time_out) begin
            ram_we                  = 1'b1;
            ram_waddr               = head_slot_r;
            ram_wdata               = tick_now;
            out_data_nxt.resend     = 1'b1;
            out_data_nxt.seq_number = head_seq_r;
          end
        end
        ACT_OPEN: begin
          credit_nxt      = in_data.credit_grant;
          entry_count_nxt = '0;
          head_slot_nxt   = '0;
          head_seq_nxt    = 32'd1;
          next_seq_nxt    = 32'd1;
        end
        default: begin
        end
      endcase
    end
    out_data_nxt.occupancy   = 6'(entry_count_nxt);
    out_data_nxt.credit_left = credit_nxt;
    byp_hit_nxt              = ram_we && (ram_waddr == head_slot_nxt);
  end

  // Window state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_slot_r   <= '0;
      entry_count_r <= '0;
      head_seq_r    <= 32'd1;
      next_seq_r    <= 32'd1;
      credit_r      <= '0;
      now_r         <= '0;
      out_valid_r   <= 1'b0;
      byp_hit_r     <= 1'b0;
    end else begin
      head_slot_r   <= head_slot_nxt;
      entry_count_r <= entry_count_nxt;
      head_seq_r    <= head_seq_nxt;
      next_seq_r    <= next_seq_nxt;
      credit_r      <= credit_nxt;
      now_r         <= now_nxt;
      byp_hit_r     <= byp_hit_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload and bypass data.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
    byp_data_r <= ram_wdata;
  end

  // Send stamps, read at the next head slot.
  sws_ram #(
    .WIDTH (32),
    .DEPTH (WINDOW_DEPTH)
  ) u_stamps (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_slot_nxt),
    .rdata (ram_rdata)
  );

  `SWS_ASSERT_NOW(a_occ_bound, 1'b1, entry_count_r <= CNT_W'(WINDOW_DEPTH), "window overfilled")
  `SWS_ASSERT_NEXT(a_fire_valid, in_fire, out_valid_r, "accepted event produced no result")
  `SWS_ASSERT_NEXT(a_resend_stamp, in_fire && (in_data.action == ACT_TICK) && time_out, head_stamp == now_r, "head stamp not refreshed on resend")
  `SWS_ASSERT_NOW(a_seq_match, out_valid_r && out_data_r.accepted, out_data_r.seq_number == next_seq_r - 32'd1, "admitted sequence out of step")

endmodule

>>> design/sws_ram.sv
`timescale 1ns / 1ps
module sws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
